>>> hdl/pls_pkg.sv
// ---------------------------------------------------------------------------
// pls_pkg
// shared types and codes for the positional list store
// ---------------------------------------------------------------------------
package pls_pkg;

  localparam int CMD_W = 2;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUMPED  = 2'd3;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic [1:0]              op;
    logic [POS_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hdl/pls_cmd_if.sv
// ---------------------------------------------------------------------------
// pls_cmd_if
// command channel: valid/ready with command, position and value
// ---------------------------------------------------------------------------
interface pls_cmd_if;
  import pls_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink (input valid, input cmd, input position, input value, output ready);
endinterface

>>> hdl/pls_rsp_if.sv
// ---------------------------------------------------------------------------
// pls_rsp_if
// result channel: valid/ready with status, element, length and last flag
// ---------------------------------------------------------------------------
interface pls_rsp_if;
  import pls_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] element;
  logic [LEN_W-1:0]        length;
  logic                    final_flag;

  modport source (output valid, output status, output element, output length,
                  output final_flag, input ready);
  modport sink (input valid, input status, input element, input length,
                input final_flag, output ready);
endinterface

>>> hdl/pls_cell.sv
// ---------------------------------------------------------------------------
// pls_cell
// one list slot; shifts toward its neighbors on insert, delete and rotate
// ---------------------------------------------------------------------------
module pls_cell #(
  parameter int INDEX = 0
) (
  input  logic                            clk,
  input  pls_pkg::cell_ctrl_t             ctrl,
  input  logic signed [pls_pkg::VAL_W-1:0] left,
  input  logic signed [pls_pkg::VAL_W-1:0] right,
  input  logic signed [pls_pkg::VAL_W-1:0] head,
  output logic signed [pls_pkg::VAL_W-1:0] q
);
  import pls_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        // new value lands here, everything behind moves one slot back
        if (MY_IDX == ctrl.idx) begin
          q <= ctrl.value;
        end else if (MY_IDX > ctrl.idx) begin
          q <= left;
        end
      end
      OP_DELETE: begin
        if (MY_IDX >= ctrl.idx) begin
          q <= right;
        end
      end
      OP_ROTATE: begin
        // idx is the last occupied slot, which takes the head value as it wraps around
        if (MY_IDX == ctrl.idx) begin
          q <= head;
        end else if (MY_IDX < ctrl.idx) begin
          q <= right;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

>>> hdl/positional_list_store_core.sv
// ---------------------------------------------------------------------------
// positional_list_store_core
// ordered list of signed 32-bit values held in a chain of shifting cells
// ---------------------------------------------------------------------------
// usage
//   req carries one command beat: insert (value before 1-based position),
//   delete (position) or dump. rsp carries the result beats, each with a
//   status, an element (dump only), the list length after the command and
//   final_flag on the last beat of the command.
// command flow
//   insert and delete shift every slot of the cell chain at once. for these,
//   full, ignored and empty-dump commands one final beat sits in the output
//   register on the next cycle. while rsp is not stalled a new command can
//   follow right behind, and a dump of n elements gives n beats, one per
//   cycle, as the chain rotates its occupied slots once through the head
//   cell; the command port stays blocked until the last beat is loaded.
// reset
//   synchronous rst empties the list and drops any pending result; slot
//   contents are not cleared since only occupied slots are ever read.
// back pressure
//   while rsp is stalled the output register holds its beat, the chain
//   and the dump counter freeze, and req.ready stays low.
// ---------------------------------------------------------------------------
module positional_list_store_core #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  pls_cmd_if.sink   req,
  pls_rsp_if.source rsp
);
  import pls_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE_S = 1'b0;
  localparam logic ST_DUMP_S = 1'b1;

  // control state
  logic             state, state_next;
  logic [OCC_W-1:0] occupancy, occupancy_next;
  logic [OCC_W-1:0] cnt, cnt_next;

  // output register
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic signed [VAL_W-1:0] out_element;
  logic [LEN_W-1:0]        out_length;
  logic                    out_final;

  // values loaded into the output register
  logic                    load;
  logic [STATUS_W-1:0]     ld_status;
  logic signed [VAL_W-1:0] ld_element;
  logic                    ld_final;

  logic       out_free;
  logic       accept;
  cell_ctrl_t ctrl;

  logic [POS_W-1:0] occ_ext;
  logic [POS_W-1:0] pos_m1;

  logic signed [VAL_W-1:0] cells_q [CAPACITY];

  // ---------------------------------------------------------------------
  // cell chain: slot 0 is position 1
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cells_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cells_q[i+1];
    end

    pls_cell #(
      .INDEX(i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .left (left_v),
      .right(right_v),
      .head (cells_q[0]),
      .q    (cells_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE_S) && out_free;
  assign accept    = req.valid && req.ready;

  assign occ_ext = POS_W'(occupancy);
  assign pos_m1  = req.position - POS_W'(1);

  // ---------------------------------------------------------------------
  // command decode and dump sequencing
  // ---------------------------------------------------------------------
  always_comb begin
    ctrl.op        = OP_HOLD;
    ctrl.idx       = '0;
    ctrl.value     = req.value;
    occupancy_next = occupancy;
    state_next     = state;
    cnt_next       = cnt;
    load           = 1'b0;
    ld_status      = ST_IGNORED;
    ld_element     = '0;
    ld_final       = 1'b1;

    case (state)
      ST_IDLE_S: begin
        if (accept) begin
          load = 1'b1;
          case (req.cmd)
            CMD_INSERT: begin
              if (req.position == '0) begin
                ld_status = ST_IGNORED;
              end else if (occupancy >= OCC_W'(CAPACITY)) begin
                ld_status = ST_FULL;
              end else begin
                // a position past the end appends
                ctrl.op        = OP_INSERT;
                ctrl.idx       = (pos_m1 > occ_ext) ? occ_ext : pos_m1;
                occupancy_next = occupancy + OCC_W'(1);
                ld_status      = ST_DONE;
              end
            end
            CMD_DELETE: begin
              if (req.position == '0 || req.position > occ_ext) begin
                ld_status = ST_IGNORED;
              end else begin
                ctrl.op        = OP_DELETE;
                ctrl.idx       = pos_m1;
                occupancy_next = occupancy - OCC_W'(1);
                ld_status      = ST_DONE;
              end
            end
            CMD_DUMP: begin
              if (occupancy == '0) begin
                ld_status = ST_DONE;
              end else begin
                // beats come out of the dump state
                load       = 1'b0;
                state_next = ST_DUMP_S;
                cnt_next   = '0;
              end
            end
            default: begin
              ld_status = ST_IGNORED;
            end
          endcase
        end
      end
      ST_DUMP_S: begin
        if (out_free) begin
          // head cell goes out, the occupied slots rotate by one
          load       = 1'b1;
          ld_status  = ST_DUMPED;
          ld_element = cells_q[0];
          ld_final   = (cnt == occupancy - OCC_W'(1));
          ctrl.op    = OP_ROTATE;
          ctrl.idx   = occ_ext - POS_W'(1);
          cnt_next   = cnt + OCC_W'(1);
          if (ld_final) begin
            state_next = ST_IDLE_S;
          end
        end
      end
      default: begin
        state_next = ST_IDLE_S;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE_S;
      occupancy <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      cnt       <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_status  <= ld_status;
      out_element <= ld_element;
      out_length  <= LEN_W'(occupancy_next);
      out_final   <= ld_final;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.element    = out_element;
  assign rsp.length     = out_length;
  assign rsp.final_flag = out_final;

endmodule

>>> hdl/pls_checker.sv
// ---------------------------------------------------------------------------
// pls_checker
// port-level checks of the positional list store, bound to positional_list_store_core
// ---------------------------------------------------------------------------
module pls_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pls_pkg::STATUS_W-1:0]  rsp_status,
  input logic [pls_pkg::VAL_W-1:0]     rsp_element,
  input logic                          rsp_final_flag
);
  import pls_pkg::*;

  // set between a non-final dump beat and the final one
  logic in_dump;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_dump <= 1'b0;
    end else if (rsp_valid && rsp_ready && rsp_status == ST_DUMPED) begin
      in_dump <= !rsp_final_flag;
    end
  end

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_element) && $stable(rsp_final_flag))
    else $error("result beat changed while stalled");

  // no command taken in the middle of a dump; the edge that takes the
  // final dump beat may also take the next command
  a_dump_block: assert property (@(posedge clk) disable iff (rst)
    in_dump && !(rsp_valid && rsp_ready && rsp_final_flag) |-> !(req_valid && req_ready))
    else $error("command accepted during dump");

  // only dumped beats carry an element
  a_elem_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DUMPED |-> rsp_element == '0)
    else $error("element set on non-dump beat");

  // every non-dump result is a single, final beat
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DUMPED |-> rsp_final_flag)
    else $error("non-dump result not flagged final");

endmodule

bind positional_list_store_core pls_checker u_pls_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_element   (rsp.element),
  .rsp_final_flag(rsp.final_flag)
);
